// ----- sv/pfrw_pkg.sv -----
// Shared constants, register map and frame command type for the frame rescale writer.
package pfrw_pkg;

	localparam int TARGET_W = 20;
	localparam logic [TARGET_W-1:0] TARGET_CLOCK = 20'd1000000;

	localparam int CLK_W      = 32;
	localparam int TONE_W     = 12;
	localparam int NOISE_W    = 5;
	localparam int ENV_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 4;
	localparam int MUTE_W     = 6;
	localparam int NUM_REGS   = 14;

	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 32;

	localparam int CMD_FIFO_DEPTH = 2;

	localparam logic [BYTE_W-1:0] SHAPE_SKIP = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_CLOCK = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MUTE_MASK    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_PLAY_ENABLE  = 2'd2;

	// sound chip register map
	localparam logic [ADDR_W-1:0] REG_TONE_A_LO = 4'd0;
	localparam logic [ADDR_W-1:0] REG_TONE_A_HI = 4'd1;
	localparam logic [ADDR_W-1:0] REG_TONE_B_LO = 4'd2;
	localparam logic [ADDR_W-1:0] REG_TONE_B_HI = 4'd3;
	localparam logic [ADDR_W-1:0] REG_TONE_C_LO = 4'd4;
	localparam logic [ADDR_W-1:0] REG_TONE_C_HI = 4'd5;
	localparam logic [ADDR_W-1:0] REG_NOISE     = 4'd6;
	localparam logic [ADDR_W-1:0] REG_MIXER     = 4'd7;
	localparam logic [ADDR_W-1:0] REG_VOL_A     = 4'd8;
	localparam logic [ADDR_W-1:0] REG_VOL_B     = 4'd9;
	localparam logic [ADDR_W-1:0] REG_VOL_C     = 4'd10;
	localparam logic [ADDR_W-1:0] REG_ENV_LO    = 4'd11;
	localparam logic [ADDR_W-1:0] REG_ENV_HI    = 4'd12;
	localparam logic [ADDR_W-1:0] REG_SHAPE     = 4'd13;

	// how a period reaches its register
	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_SAT,
		MODE_DIV
	} period_mode_t;

	typedef struct packed {
		logic [TONE_W-1:0]  tone_a;
		logic [TONE_W-1:0]  tone_b;
		logic [TONE_W-1:0]  tone_c;
		logic [NOISE_W-1:0] noise;
		logic [ENV_W-1:0]   env;
		period_mode_t       mode_a;
		period_mode_t       mode_b;
		period_mode_t       mode_c;
		period_mode_t       mode_n;
		period_mode_t       mode_e;
		logic [BYTE_W-1:0]  mixer;
		logic [BYTE_W-1:0]  vol_a;
		logic [BYTE_W-1:0]  vol_b;
		logic [BYTE_W-1:0]  vol_c;
		logic [BYTE_W-1:0]  shape;
		logic               has_shape;
	} cmd_t;

endpackage

// ----- sv/pfrw_front.sv -----
// Front end: configuration registers, frame intake and per-period classification.
module pfrw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pfrw_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                cfg_valid,
	input  logic [pfrw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pfrw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                fifo_full,
	output logic                                push,
	output pfrw_pkg::cmd_t                      cmd,
	output logic [pfrw_pkg::CLK_W-1:0]          source_clock
);

	logic [pfrw_pkg::CLK_W-1:0]  source_clock_q;
	logic [pfrw_pkg::MUTE_W-1:0] mute_q;
	logic                        play_q;
	logic                        clk_is_target;
	logic                        clk_is_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_clock_q <= pfrw_pkg::CLK_W'(pfrw_pkg::TARGET_CLOCK);
			mute_q         <= '0;
			play_q         <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_addr)
				pfrw_pkg::CFG_SOURCE_CLOCK: source_clock_q <= cfg_data;
				pfrw_pkg::CFG_MUTE_MASK:    mute_q <= cfg_data[pfrw_pkg::MUTE_W-1:0];
				pfrw_pkg::CFG_PLAY_ENABLE:  play_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic pfrw_pkg::period_mode_t classify(input logic is_zero,
			input logic tgt, input logic clk0);
		if (is_zero || tgt)
			return pfrw_pkg::MODE_PASS;
		else if (clk0)
			return pfrw_pkg::MODE_SAT;
		else
			return pfrw_pkg::MODE_DIV;
	endfunction

	assign clk_is_target = (source_clock_q == pfrw_pkg::CLK_W'(pfrw_pkg::TARGET_CLOCK));
	assign clk_is_zero   = (source_clock_q == '0);

	always_comb begin
		cmd.tone_a = s_tdata[11:0];
		cmd.tone_b = s_tdata[23:12];
		cmd.tone_c = s_tdata[35:24];
		cmd.noise  = s_tdata[40:36];
		cmd.env    = s_tdata[88:73];
		cmd.mode_a = classify(cmd.tone_a == '0, clk_is_target, clk_is_zero);
		cmd.mode_b = classify(cmd.tone_b == '0, clk_is_target, clk_is_zero);
		cmd.mode_c = classify(cmd.tone_c == '0, clk_is_target, clk_is_zero);
		cmd.mode_n = classify(cmd.noise == '0, clk_is_target, clk_is_zero);
		cmd.mode_e = classify(cmd.env == '0, clk_is_target, clk_is_zero);
		// mute bits 3..5 land on the mixer noise disables
		cmd.mixer  = s_tdata[48:41] | {2'b00, mute_q[5:3], 3'b000};
		cmd.vol_a  = mute_q[0] ? '0 : s_tdata[56:49];
		cmd.vol_b  = mute_q[1] ? '0 : s_tdata[64:57];
		cmd.vol_c  = mute_q[2] ? '0 : s_tdata[72:65];
		cmd.shape  = s_tdata[96:89];
		cmd.has_shape = (s_tdata[96:89] != pfrw_pkg::SHAPE_SKIP);
	end

	// drop the frame when playback is off
	assign s_tready     = !fifo_full;
	assign push         = s_tvalid && !fifo_full && play_q;
	assign source_clock = source_clock_q;

endmodule

// ----- sv/pfrw_fifo.sv -----
// Short command queue between the front end and the back end.
module pfrw_fifo #(
	parameter int DEPTH = pfrw_pkg::CMD_FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfrw_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output pfrw_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfrw_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/pfrw_div.sv -----
// Restoring divider: floor(period * 1000000 / divisor) wrapped to PW bits, one quotient bit per cycle.
module pfrw_div #(
	parameter int PW = pfrw_pkg::TONE_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [PW-1:0]              period,
	input  logic [pfrw_pkg::CLK_W-1:0] divisor,
	output logic                       busy,
	output logic [PW-1:0]              quotient
);

	localparam int NW    = PW + pfrw_pkg::TARGET_W;
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]              num_q;
	logic [pfrw_pkg::CLK_W-1:0] rem_q;
	logic [PW-1:0]              quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic [pfrw_pkg::CLK_W:0]   trial;
	logic [pfrw_pkg::CLK_W+1:0] diff;
	logic                       fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, divisor};
	assign fits  = !diff[pfrw_pkg::CLK_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(period) * NW'(pfrw_pkg::TARGET_CLOCK);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[pfrw_pkg::CLK_W-1:0] : trial[pfrw_pkg::CLK_W-1:0];
			quo_q <= {quo_q[PW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- sv/pfrw_back.sv -----
// Back end: period rescaling, pending register bytes and the register write stream.
module pfrw_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fifo_empty,
	input  pfrw_pkg::cmd_t                       head,
	output logic                                 pop,
	input  logic [pfrw_pkg::CLK_W-1:0]           source_clock,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [pfrw_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	div_state_t                  state_q;
	pfrw_pkg::cmd_t              cmd_q;
	logic [pfrw_pkg::BYTE_W-1:0] pending_q [pfrw_pkg::NUM_REGS];
	logic [pfrw_pkg::ADDR_W-1:0] idx_q;
	logic [pfrw_pkg::ADDR_W-1:0] last_idx_q;
	logic                        emit_active_q;
	logic                        m_tvalid_q;
	logic [pfrw_pkg::ADDR_W-1:0] m_addr_q;
	logic [pfrw_pkg::BYTE_W-1:0] m_data_q;
	logic                        m_tlast_q;

	logic                        start_a, start_b, start_c, start_n, start_e;
	logic                        busy_a, busy_b, busy_c, busy_n, busy_e;
	logic [pfrw_pkg::TONE_W-1:0] quo_a, quo_b, quo_c;
	logic [pfrw_pkg::NOISE_W-1:0] quo_n;
	logic [pfrw_pkg::ENV_W-1:0]  quo_e;
	logic                        any_busy;
	logic                        load;
	logic                        advance;
	logic [pfrw_pkg::ENV_W-1:0]  ta, tb, tc, np, ep;

	assign pop     = (state_q == DIV_IDLE) && !fifo_empty;
	assign start_a = pop && (head.mode_a == pfrw_pkg::MODE_DIV);
	assign start_b = pop && (head.mode_b == pfrw_pkg::MODE_DIV);
	assign start_c = pop && (head.mode_c == pfrw_pkg::MODE_DIV);
	assign start_n = pop && (head.mode_n == pfrw_pkg::MODE_DIV);
	assign start_e = pop && (head.mode_e == pfrw_pkg::MODE_DIV);

	pfrw_div #(.PW(pfrw_pkg::TONE_W)) u_div_a (
		.clk, .arst_n, .start(start_a), .period(head.tone_a), .divisor(source_clock),
		.busy(busy_a), .quotient(quo_a));
	pfrw_div #(.PW(pfrw_pkg::TONE_W)) u_div_b (
		.clk, .arst_n, .start(start_b), .period(head.tone_b), .divisor(source_clock),
		.busy(busy_b), .quotient(quo_b));
	pfrw_div #(.PW(pfrw_pkg::TONE_W)) u_div_c (
		.clk, .arst_n, .start(start_c), .period(head.tone_c), .divisor(source_clock),
		.busy(busy_c), .quotient(quo_c));
	pfrw_div #(.PW(pfrw_pkg::NOISE_W)) u_div_n (
		.clk, .arst_n, .start(start_n), .period(head.noise), .divisor(source_clock),
		.busy(busy_n), .quotient(quo_n));
	pfrw_div #(.PW(pfrw_pkg::ENV_W)) u_div_e (
		.clk, .arst_n, .start(start_e), .period(head.env), .divisor(source_clock),
		.busy(busy_e), .quotient(quo_e));

	assign any_busy = busy_a || busy_b || busy_c || busy_n || busy_e;
	assign load     = (state_q == DIV_RUN) && !any_busy && !emit_active_q;
	assign advance  = emit_active_q && (!m_tvalid_q || m_tready);

	// pass the period, saturate to all ones, or take the quotient
	function automatic logic [pfrw_pkg::ENV_W-1:0] pick(input pfrw_pkg::period_mode_t mode,
			input logic [pfrw_pkg::ENV_W-1:0] period, input logic [pfrw_pkg::ENV_W-1:0] quo,
			input logic [pfrw_pkg::ENV_W-1:0] ones);
		case (mode)
			pfrw_pkg::MODE_PASS: return period;
			pfrw_pkg::MODE_SAT:  return ones;
			pfrw_pkg::MODE_DIV:  return quo;
			default:             return period;
		endcase
	endfunction

	always_comb begin
		ta = pick(cmd_q.mode_a, pfrw_pkg::ENV_W'(cmd_q.tone_a), pfrw_pkg::ENV_W'(quo_a),
			pfrw_pkg::ENV_W'({pfrw_pkg::TONE_W{1'b1}}));
		tb = pick(cmd_q.mode_b, pfrw_pkg::ENV_W'(cmd_q.tone_b), pfrw_pkg::ENV_W'(quo_b),
			pfrw_pkg::ENV_W'({pfrw_pkg::TONE_W{1'b1}}));
		tc = pick(cmd_q.mode_c, pfrw_pkg::ENV_W'(cmd_q.tone_c), pfrw_pkg::ENV_W'(quo_c),
			pfrw_pkg::ENV_W'({pfrw_pkg::TONE_W{1'b1}}));
		np = pick(cmd_q.mode_n, pfrw_pkg::ENV_W'(cmd_q.noise), pfrw_pkg::ENV_W'(quo_n),
			pfrw_pkg::ENV_W'({pfrw_pkg::NOISE_W{1'b1}}));
		ep = pick(cmd_q.mode_e, cmd_q.env, quo_e, {pfrw_pkg::ENV_W{1'b1}});
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head;
		if (load) begin
			pending_q[pfrw_pkg::REG_TONE_A_LO] <= ta[7:0];
			pending_q[pfrw_pkg::REG_TONE_A_HI] <= {4'h0, ta[11:8]};
			pending_q[pfrw_pkg::REG_TONE_B_LO] <= tb[7:0];
			pending_q[pfrw_pkg::REG_TONE_B_HI] <= {4'h0, tb[11:8]};
			pending_q[pfrw_pkg::REG_TONE_C_LO] <= tc[7:0];
			pending_q[pfrw_pkg::REG_TONE_C_HI] <= {4'h0, tc[11:8]};
			pending_q[pfrw_pkg::REG_NOISE]     <= {3'b000, np[4:0]};
			pending_q[pfrw_pkg::REG_MIXER]     <= cmd_q.mixer;
			pending_q[pfrw_pkg::REG_VOL_A]     <= cmd_q.vol_a;
			pending_q[pfrw_pkg::REG_VOL_B]     <= cmd_q.vol_b;
			pending_q[pfrw_pkg::REG_VOL_C]     <= cmd_q.vol_c;
			pending_q[pfrw_pkg::REG_ENV_LO]    <= ep[7:0];
			pending_q[pfrw_pkg::REG_ENV_HI]    <= ep[15:8];
			pending_q[pfrw_pkg::REG_SHAPE]     <= cmd_q.shape;
		end
		if (advance) begin
			m_addr_q  <= idx_q;
			m_data_q  <= pending_q[idx_q];
			m_tlast_q <= (idx_q == last_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= DIV_IDLE;
			emit_active_q <= 1'b0;
			idx_q         <= '0;
			last_idx_q    <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			case (state_q)
				DIV_IDLE: if (pop) state_q <= DIV_RUN;
				DIV_RUN:  if (load) state_q <= DIV_IDLE;
				default:  state_q <= DIV_IDLE;
			endcase
			if (load) begin
				emit_active_q <= 1'b1;
				idx_q         <= pfrw_pkg::REG_TONE_A_LO;
				last_idx_q    <= cmd_q.has_shape ? pfrw_pkg::REG_SHAPE : pfrw_pkg::REG_ENV_HI;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == last_idx_q)
					emit_active_q <= 1'b0;
			end
			if (advance)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'h0, m_data_q, m_addr_q};
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_last_on_final_reg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tlast_q |-> (m_addr_q == pfrw_pkg::REG_ENV_HI ||
			m_addr_q == pfrw_pkg::REG_SHAPE))
		else $error("last write flagged on a register other than 12 or 13");

	a_addr_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tready && !m_tlast_q |=> m_tvalid_q &&
			(m_addr_q == $past(m_addr_q) + 1'b1))
		else $error("register writes of a frame not consecutive");

	a_div_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		any_busy |-> (state_q == DIV_RUN))
		else $error("divider busy outside the rescale phase");

	a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		emit_active_q && !advance |=> $stable(idx_q))
		else $error("write index moved while the output was stalled");
`endif

endmodule

// ----- sv/psg_frame_rescale_writer_top.sv -----
// Top level of the frame rescale writer: sound-chip frames in, register writes out.
// Flow: a taken frame waits in the command queue, is popped into the command register, has
//   its periods rescaled by the bit-serial dividers where needed, loads the pending bytes,
//   and each byte leaves through the output register: 13 writes, or 14 with a shape write.
//   The next frame is popped and rescaled while these writes go out, and loads after them.
// Reset: arst_n clears all control at once; source clock 1 MHz, no mute, playback on.
module psg_frame_rescale_writer_top #(
	parameter int CMD_DEPTH = pfrw_pkg::CMD_FIFO_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// frame words: tone_a[11:0] tone_b[23:12] tone_c[35:24] noise_period[40:36]
	// mixer_bits[48:41] volume_a[56:49] volume_b[64:57] volume_c[72:65]
	// envelope_period[88:73] envelope_shape[96:89], zero fill above
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pfrw_pkg::IN_TDATA_W-1:0]     s_tdata,
	// register write words: reg_addr[3:0] reg_data[11:4], zero fill above
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pfrw_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	// configuration: 0 source clock, 1 mute mask, 2 play enable
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pfrw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pfrw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pfrw_pkg::cmd_t             wr_cmd;
	pfrw_pkg::cmd_t             head;
	logic                       push;
	logic                       pop;
	logic                       fifo_full;
	logic                       fifo_empty;
	logic [pfrw_pkg::CLK_W-1:0] source_clock;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	// front: hold the config, classify each period, drop frames while playback is off
	pfrw_front u_front (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.cfg_valid, .cfg_addr, .cfg_data,
		.fifo_full,
		.push,
		.cmd(wr_cmd),
		.source_clock
	);

	// queue: let the front take the next frame while the back is still writing
	pfrw_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
		.clk, .arst_n,
		.push,
		.wr_cmd,
		.pop,
		.head,
		.full(fifo_full),
		.empty(fifo_empty)
	);

	// back: rescale the periods, then advance through the pending register bytes
	pfrw_back u_back (
		.clk, .arst_n,
		.fifo_empty,
		.head,
		.pop,
		.source_clock,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

endmodule

// ----- tb/psg_frame_rescale_writer_top_tb.sv -----
// Self-checking testbench for the frame rescale writer: random frames, clock settings and stalls.
module psg_frame_rescale_writer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfrw_pkg::*;

	localparam int WATCHDOG_CYCLES = 400000;
	// the slowest frame waits for its dividers before its first write and up to two frames
	// can sit in the command queue, so this covers anything still in flight
	localparam int SETTLE_CYCLES = 150;

	// one sound-chip frame as it travels on the input stream, tone_a in the lowest bits
	typedef struct packed {
		logic [BYTE_W-1:0]  shape;
		logic [ENV_W-1:0]   env;
		logic [BYTE_W-1:0]  vol_c;
		logic [BYTE_W-1:0]  vol_b;
		logic [BYTE_W-1:0]  vol_a;
		logic [BYTE_W-1:0]  mixer;
		logic [NOISE_W-1:0] noise;
		logic [TONE_W-1:0]  tone_c;
		logic [TONE_W-1:0]  tone_b;
		logic [TONE_W-1:0]  tone_a;
	} frame_t;

	// one register write as it should leave the block
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic              last;
	} chip_write_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor's copy of the configuration, mirrored at each accepted register write
	logic [CLK_W-1:0]  song_clock = TARGET_CLOCK;
	logic [MUTE_W-1:0] mute_bits = '0;
	logic              playing = 1'b1;

	frame_t      frames_to_send[$];
	chip_write_t due_writes[$];
	frame_t      frame_on_bus;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int frames_pushed = 0;
	int frames_taken = 0;
	int writes_checked = 0;
	int clock_settings = 0;
	int mismatches = 0;
	int cycle_count = 0;

	psg_frame_rescale_writer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Scale a period from the song's clock to the 1 MHz chip, wrapping to the register width.
	function automatic logic [ENV_W-1:0] rescaled_period(input logic [ENV_W-1:0] period,
			input logic [ENV_W-1:0] width_mask);
		logic [63:0] quotient;
		if (period == '0 || song_clock == CLK_W'(TARGET_CLOCK))
			return period & width_mask;
		// a zero clock has no divide: every live period saturates to all ones
		if (song_clock == '0)
			return width_mask;
		quotient = (64'(period) * 64'(TARGET_CLOCK)) / 64'(song_clock);
		return quotient[ENV_W-1:0] & width_mask;
	endfunction

	// Work out the register writes that one accepted frame must produce and queue them.
	task automatic predict_writes(input frame_t f);
		logic [BYTE_W-1:0] chip_regs [NUM_REGS];
		logic [ENV_W-1:0]  ta, tb, tc, np, ep;
		int                n_writes;
		chip_write_t       w;
		ta = rescaled_period(ENV_W'(f.tone_a), 16'h0FFF);
		tb = rescaled_period(ENV_W'(f.tone_b), 16'h0FFF);
		tc = rescaled_period(ENV_W'(f.tone_c), 16'h0FFF);
		np = rescaled_period(ENV_W'(f.noise), 16'h001F);
		ep = rescaled_period(f.env, 16'hFFFF);
		chip_regs[REG_TONE_A_LO] = ta[7:0];
		chip_regs[REG_TONE_A_HI] = {4'h0, ta[11:8]};
		chip_regs[REG_TONE_B_LO] = tb[7:0];
		chip_regs[REG_TONE_B_HI] = {4'h0, tb[11:8]};
		chip_regs[REG_TONE_C_LO] = tc[7:0];
		chip_regs[REG_TONE_C_HI] = {4'h0, tc[11:8]};
		chip_regs[REG_NOISE]     = {3'h0, np[4:0]};
		// upper mute bits force the noise disables on
		chip_regs[REG_MIXER]     = f.mixer | {2'b00, mute_bits[5:3], 3'b000};
		chip_regs[REG_VOL_A]     = mute_bits[0] ? '0 : f.vol_a;
		chip_regs[REG_VOL_B]     = mute_bits[1] ? '0 : f.vol_b;
		chip_regs[REG_VOL_C]     = mute_bits[2] ? '0 : f.vol_c;
		chip_regs[REG_ENV_LO]    = ep[7:0];
		chip_regs[REG_ENV_HI]    = ep[15:8];
		chip_regs[REG_SHAPE]     = f.shape;
		if (!playing)
			return;
		// a skip shape drops the final write, so the envelope high byte closes the frame
		n_writes = (f.shape == SHAPE_SKIP) ? NUM_REGS - 1 : NUM_REGS;
		for (int k = 0; k < n_writes; k++) begin
			w.addr = ADDR_W'(k);
			w.data = chip_regs[k];
			w.last = (k == n_writes - 1);
			due_writes.push_back(w);
		end
	endtask

	// Driver: offer queued frames, hold a word until taken, idle at random between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			frames_taken <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_writes(frame_on_bus);
				frames_taken <= frames_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (frames_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					frame_on_bus = frames_to_send.pop_front();
					s_tdata <= IN_TDATA_W'(frame_on_bus);
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each accepted write with the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		chip_write_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				writes_checked++;
				if (due_writes.size() == 0) begin
					flag_mismatch("unexpected write, address", int'(m_tdata[3:0]), 0);
				end else begin
					want = due_writes.pop_front();
					if (m_tdata[3:0] != want.addr)
						flag_mismatch("reg_addr", int'(m_tdata[3:0]), int'(want.addr));
					if (m_tdata[11:4] != want.data)
						flag_mismatch($sformatf("reg_data of reg %0d", want.addr),
							int'(m_tdata[11:4]), int'(want.data));
					if (m_tlast !== want.last)
						flag_mismatch($sformatf("last_write of reg %0d", want.addr),
							int'(m_tlast), int'(want.last));
					if (m_tdata[15:12] != '0)
						flag_mismatch("tdata zero fill", int'(m_tdata[15:12]), 0);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= WATCHDOG_CYCLES) begin
			$display("Timeout after %0d cycles, %0d writes still due", cycle_count,
				due_writes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Write one configuration register and mirror it once the word is taken.
	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SOURCE_CLOCK: song_clock = val;
			CFG_MUTE_MASK:    mute_bits = val[MUTE_W-1:0];
			CFG_PLAY_ENABLE:  playing = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CLK_W-1:0] clk_hz, input logic [MUTE_W-1:0] mute,
			input logic play);
		cfg_write(CFG_SOURCE_CLOCK, clk_hz);
		cfg_write(CFG_MUTE_MASK, CFG_DATA_W'(mute));
		cfg_write(CFG_PLAY_ENABLE, CFG_DATA_W'(play));
		clock_settings++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic queue_frame(input frame_t f);
		frames_to_send.push_back(f);
		frames_pushed++;
	endtask

	// Extremes and alternating bit patterns of every field, with and without the skip shape.
	task automatic queue_edge_frames();
		queue_frame('0);
		queue_frame('{tone_a: '1, tone_b: '1, tone_c: '1, noise: '1, mixer: '1, vol_a: '1,
			vol_b: '1, vol_c: '1, env: '1, shape: 8'hFE});
		queue_frame('{tone_a: '1, tone_b: 12'h001, tone_c: 12'h800, noise: 5'h01, mixer: '0,
			vol_a: 8'h0F, vol_b: 8'hF0, vol_c: 8'h01, env: 16'h0001, shape: SHAPE_SKIP});
		queue_frame('{tone_a: 12'hAAA, tone_b: 12'h555, tone_c: 12'hA5A, noise: 5'h15,
			mixer: 8'hAA, vol_a: 8'h55, vol_b: 8'hAA, vol_c: 8'h55, env: 16'hAAAA,
			shape: 8'h55});
		queue_frame('{tone_a: 12'h555, tone_b: 12'hAAA, tone_c: 12'h5A5, noise: 5'h0A,
			mixer: 8'h55, vol_a: 8'hAA, vol_b: 8'h55, vol_c: 8'hAA, env: 16'h5555,
			shape: 8'hAA});
	endtask

	// Random frames; periods fall to zero and the shape to skip now and then.
	task automatic queue_random_frames(input int count);
		frame_t f;
		repeat (count) begin
			f.tone_a = ($urandom_range(5) == 0) ? '0 : TONE_W'($urandom());
			f.tone_b = ($urandom_range(5) == 0) ? '0 : TONE_W'($urandom());
			f.tone_c = ($urandom_range(5) == 0) ? '0 : TONE_W'($urandom());
			f.noise  = ($urandom_range(5) == 0) ? '0 : NOISE_W'($urandom());
			f.env    = ($urandom_range(5) == 0) ? '0 : ENV_W'($urandom());
			f.mixer  = BYTE_W'($urandom());
			f.vol_a  = BYTE_W'($urandom());
			f.vol_b  = BYTE_W'($urandom());
			f.vol_c  = BYTE_W'($urandom());
			f.shape  = ($urandom_range(7) == 0) ? SHAPE_SKIP : BYTE_W'($urandom());
			queue_frame(f);
		end
	endtask

	// Hold until every frame is taken and every write has come, then let the pipe drain.
	task automatic settle();
		do @(posedge clk); while (frames_taken != frames_pushed || due_writes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through clock: periods must arrive untouched
		set_config(CLK_W'(TARGET_CLOCK), 6'h00, 1'b1);
		set_idling(0, 0);
		queue_edge_frames();
		queue_random_frames(40);
		settle();

		// doubled song clock halves every period; mute everything; pause the sender midway
		set_config(32'd2000000, 6'h3F, 1'b1);
		set_idling(59, 0);
		queue_edge_frames();
		queue_random_frames(25);
		settle();
		queue_random_frames(25);
		settle();

		// slowest possible clock: quotients overflow and wrap
		set_config(32'd1, 6'h15, 1'b1);
		set_idling(0, 59);
		queue_edge_frames();
		queue_random_frames(50);
		settle();

		// fastest clock: every tone and noise period rescales to zero, the envelope to at most 15
		set_config(32'hFFFF_FFFF, 6'h2A, 1'b1);
		set_idling(7, 7);
		queue_edge_frames();
		queue_random_frames(40);
		settle();

		// zero clock: every live period saturates
		set_config(32'd0, 6'h07, 1'b1);
		set_idling(0, 59);
		queue_edge_frames();
		queue_random_frames(30);
		settle();

		// playback off: frames are swallowed and nothing must come out
		set_config(32'd1773400, 6'h00, 1'b0);
		set_idling(0, 0);
		queue_random_frames(20);
		settle();

		// typical song clocks with playback back on
		set_config(32'd1773400, 6'h38, 1'b1);
		set_idling(7, 7);
		queue_random_frames(40);
		settle();

		set_config(32'd500000, 6'h00, 1'b1);
		set_idling(59, 0);
		queue_random_frames(35);
		settle();

		set_config(CLK_W'($urandom_range(4000000, 100000)), MUTE_W'($urandom()), 1'b1);
		set_idling(0, 0);
		queue_random_frames(50);
		settle();

		if (due_writes.size() != 0)
			flag_mismatch("writes left over at end", due_writes.size(), 0);

		$display("Sent %0d frames under %0d clock and mute settings, checked %0d writes",
			frames_pushed, clock_settings, writes_checked);
		$display("Idling phases: none, sender, receiver and both; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/pfrw_pkg.sv
sv/pfrw_front.sv
sv/pfrw_fifo.sv
sv/pfrw_div.sv
sv/pfrw_back.sv
sv/psg_frame_rescale_writer_top.sv
tb/psg_frame_rescale_writer_top_tb.sv
